// ----- rtl/mlhf_pkg.sv -----
// shared types and constants for the uplink health and failover block
`default_nettype none

package mlhf_pkg;

    localparam int MAX_HOSTS   = 32;
    localparam int HIDX_W      = 5;
    localparam int HOSTS_DEF   = 8;
    localparam int WINDOW_DEF  = 8;
    localparam int SEQ_W       = 16;
    localparam int HOST_W      = 3;
    localparam int MASK_W      = 8;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_FIRST = 2'd1;

    localparam logic FUNC_REPLY = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // lowest up host found so far along the chain
    typedef struct packed {
        logic              have;
        logic [HIDX_W-1:0] idx;
    } t_carry;

endpackage

`default_nettype wire

// ----- rtl/multihome_link_health_failover_core.sv -----
// top level: host cell chain, round sequencer, route choice and result register
// a reply word is taken while the input is ready and gives no result
// a tick word runs a token down the chain of HOSTS cells, one cell per cycle, then the done
// state chooses the route and loads the result once the output register is free; the first
// tick after reset skips the chain; the input waits until the result of a tick is loaded
// synchronous active-low reset: all hosts down, no route, sequence zero, first round pending
`default_nettype none

module multihome_link_health_failover_core
    import mlhf_pkg::*;
#(
    parameter int HOSTS  = HOSTS_DEF,
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_func,
    input  wire logic [HOST_W-1:0]     i_reply_host,
    input  wire logic [SEQ_W-1:0]      i_reply_seq,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SEQ_W-1:0]           o_ping_seq,
    output logic [MASK_W-1:0]          o_up_mask,
    output logic [MASK_W-1:0]          o_went_up,
    output logic [MASK_W-1:0]          o_went_down,
    output logic                       o_route_valid,
    output logic [HOST_W-1:0]          o_route_host,
    output logic                       o_route_changed,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_host_count;
    logic              r_follow;
    logic [SEQ_W-1:0]  r_round_seq;
    logic              r_first_round;
    logic              r_have;
    logic [HIDX_W-1:0] r_first_idx;
    logic              r_route_ok;
    logic [HIDX_W-1:0] r_route_idx;
    logic              r_out_valid;

    logic [SEQ_W-1:0]  r_ping_seq;
    logic [MASK_W-1:0] r_up_mask;
    logic [MASK_W-1:0] r_went_up;
    logic [MASK_W-1:0] r_went_down;
    logic              r_route_valid;
    logic [HOST_W-1:0] r_route_host;
    logic              r_route_changed;

    logic in_acc;
    logic reply_acc;
    logic tick_acc;
    logic seq_hit;
    logic load;
    logic change;
    logic new_ok;
    logic [HIDX_W-1:0] new_idx;

    logic [HOSTS:0]      tok;
    t_carry              carry [0:HOSTS];
    logic [HOSTS-1:0]    use_vec;
    logic [HOSTS-1:0]    set_vec;
    logic [HOSTS-1:0]    up_vec;
    logic [HOSTS-1:0]    wup_vec;
    logic [HOSTS-1:0]    wdn_vec;
    logic [MAX_HOSTS-1:0] up_ext;

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_cfg_ready = 1'b1;
        in_acc      = i_in_valid && o_in_ready;
        reply_acc   = in_acc && (i_func == FUNC_REPLY);
        tick_acc    = in_acc && (i_func == FUNC_TICK);
        seq_hit     = (i_reply_seq == r_round_seq);
        load        = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    assign tok[0]        = tick_acc && !r_first_round;
    assign carry[0].have = 1'b0;
    assign carry[0].idx  = '0;

    for (genvar z = 0; z < HOSTS; z++) begin : g_cell
        assign use_vec[z] = (32'(r_host_count) > 32'(z));
        assign set_vec[z] = reply_acc && seq_hit && use_vec[z]
                            && (32'(i_reply_host) == 32'(z));

        mlhf_cell #(
            .IDX    (z),
            .WINDOW (WINDOW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_use       (use_vec[z]),
            .i_set_ans   (set_vec[z]),
            .i_clr_ans   (load),
            .i_clr_evt   (tick_acc),
            .i_tok       (tok[z]),
            .i_carry     (carry[z]),
            .o_tok       (tok[z+1]),
            .o_carry     (carry[z+1]),
            .o_up        (up_vec[z]),
            .o_went_up   (wup_vec[z]),
            .o_went_down (wdn_vec[z])
        );
    end

    assign up_ext = MAX_HOSTS'(up_vec);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (tick_acc) begin
                    n_state = r_first_round ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok[HOSTS]) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // route choice once the scan has found the lowest up host
    always_comb begin
        if (r_follow) begin
            change = (r_have != r_route_ok) || (r_have && (r_first_idx != r_route_idx));
        end else begin
            change = r_have && (!r_route_ok || !up_ext[r_route_idx]);
        end
        new_ok  = change ? r_have : r_route_ok;
        new_idx = change ? (r_have ? r_first_idx : '0) : r_route_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_host_count  <= CNT_W'(1);
            r_follow      <= 1'b0;
            r_round_seq   <= '0;
            r_first_round <= 1'b1;
            r_route_ok    <= 1'b0;
            r_route_idx   <= '0;
            r_out_valid   <= 1'b0;
            r_have        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HOST_COUNT:   r_host_count <= i_cfg_data[CNT_W-1:0];
                    CFG_FOLLOW_FIRST: r_follow     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (tick_acc) begin
                r_first_round <= 1'b0;
                if (r_first_round) begin
                    r_have <= 1'b0;
                end else begin
                    r_round_seq <= r_round_seq + 1'b1;
                end
            end
            if (r_state == ST_SCAN && tok[HOSTS]) begin
                r_have <= carry[HOSTS].have;
            end
            if (load) begin
                r_route_ok  <= new_ok;
                r_route_idx <= new_idx;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && tok[HOSTS]) begin
            r_first_idx <= carry[HOSTS].idx;
        end
        if (load) begin
            r_ping_seq      <= r_round_seq;
            r_up_mask       <= MASK_W'(up_vec);
            r_went_up       <= MASK_W'(wup_vec);
            r_went_down     <= MASK_W'(wdn_vec);
            r_route_valid   <= new_ok;
            r_route_host    <= new_ok ? new_idx[HOST_W-1:0] : '0;
            r_route_changed <= change;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ping_seq      = r_ping_seq;
    assign o_up_mask       = r_up_mask;
    assign o_went_up       = r_went_up;
    assign o_went_down     = r_went_down;
    assign o_route_valid   = r_route_valid;
    assign o_route_host    = r_route_host;
    assign o_route_changed = r_route_changed;

    // at most one cell holds the scan token
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok))
        else $error("more than one cell holds the scan token");

    a_no_route_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_route_valid |-> o_route_host == '0)
        else $error("route host shown without a route");

    a_events_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_went_up & o_went_down) == '0)
        else $error("host both went up and down on one tick");

    a_up_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_went_up & ~o_up_mask) == '0)
        else $error("host went up but is not in the up mask");

endmodule

`default_nettype wire

// ----- rtl/mlhf_cell.sv -----
// one host cell: answer bit, history window, fill count, up state, event flags and scan carry
`default_nettype none

module mlhf_cell
    import mlhf_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_use,
    input  wire logic   i_set_ans,
    input  wire logic   i_clr_ans,
    input  wire logic   i_clr_evt,
    input  wire logic   i_tok,
    input  wire t_carry i_carry,
    output logic        o_tok,
    output t_carry      o_carry,
    output logic        o_up,
    output logic        o_went_up,
    output logic        o_went_down
);

    localparam int FW = $clog2(WINDOW + 1);

    logic [WINDOW-1:0] r_hist, n_hist;
    logic [FW-1:0]     r_fill, n_fill;
    logic              r_up, n_up;
    logic              r_ans, n_ans;
    logic              r_wup, n_wup;
    logic              r_wdn, n_wdn;
    logic              r_tok;
    t_carry            r_carry, n_carry;

    logic [WINDOW-1:0] shifted;
    logic              full;
    logic              go_up;
    logic              go_dn;
    logic              step;

    always_comb begin
        step    = i_tok && i_use;
        shifted = {r_hist[WINDOW-2:0], r_ans};
        // fill is at the window once this step is taken
        full    = (r_fill >= FW'(WINDOW - 1));
        go_up   = full && (&shifted) && !r_up;
        go_dn   = full && !(|shifted) && r_up;

        n_hist  = r_hist;
        n_fill  = r_fill;
        n_up    = r_up;
        n_wup   = i_clr_evt ? 1'b0 : r_wup;
        n_wdn   = i_clr_evt ? 1'b0 : r_wdn;
        n_carry = i_carry;

        if (step) begin
            n_hist = shifted;
            if (r_fill < FW'(WINDOW)) begin
                n_fill = r_fill + 1'b1;
            end
            if (go_up) begin
                n_up  = 1'b1;
                n_wup = 1'b1;
            end else if (go_dn) begin
                n_up  = 1'b0;
                n_wdn = 1'b1;
            end
            if (!i_carry.have && n_up) begin
                n_carry.have = 1'b1;
                n_carry.idx  = HIDX_W'(IDX);
            end
        end

        if (i_clr_ans) begin
            n_ans = 1'b0;
        end else if (i_set_ans) begin
            n_ans = 1'b1;
        end else begin
            n_ans = r_ans;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_fill <= '0;
            r_up   <= 1'b0;
            r_ans  <= 1'b0;
            r_wup  <= 1'b0;
            r_wdn  <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_hist <= n_hist;
            r_fill <= n_fill;
            r_up   <= n_up;
            r_ans  <= n_ans;
            r_wup  <= n_wup;
            r_wdn  <= n_wdn;
            r_tok  <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_carry <= n_carry;
        end
    end

    assign o_tok       = r_tok;
    assign o_carry     = r_carry;
    assign o_up        = r_up;
    assign o_went_up   = r_wup;
    assign o_went_down = r_wdn;

endmodule

`default_nettype wire
